/* hdl/lecu_pkg.sv */
package lecu_pkg;

  // Component format: CW-bit signed two's complement, FB fraction bits
  localparam int CW    = 32;
  localparam int FB    = 16;
  // Internal accumulator width; values are held within +-(2^(ACC_W-1)-1)
  localparam int ACC_W = 48;
  // Depth of the item pipeline: valid shift register and context stages
  localparam int LAT   = 30;
  // Multiplier units in the datapath
  localparam int NMUL  = 35;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [ACC_W:0]   wide_t;

  localparam acc_t  ACC_MAX = acc_t'({1'b0, {(ACC_W-1){1'b1}}});
  localparam wide_t WMAX    = wide_t'(ACC_MAX);
  localparam acc_t  CMAX    = acc_t'({1'b0, {(CW-1){1'b1}}});
  localparam acc_t  CMIN    = -CMAX - acc_t'(1);

  localparam acc_t ONE     = acc_t'(1 << FB);
  localparam acc_t HALF    = acc_t'(1 << (FB - 1));
  localparam acc_t QUARTER = acc_t'(1 << (FB - 2));
  localparam acc_t K0      = acc_t'(10 << FB);
  localparam acc_t K20     = acc_t'(20 << FB);

  // Register reset values
  localparam logic [31:0] RST_ONE   = 32'(1 << FB);
  localparam logic [31:0] RST_RATIO = 32'(1 << (FB - 1));
  localparam logic [30:0] RST_TS    = 31'd6554;

  typedef enum logic [2:0] {
    REG_INV_STEP_X,
    REG_INV_STEP_Y_SQ,
    REG_INV_STEP_Z_SQ,
    REG_DELTA_COEF,
    REG_TIME_STEP,
    REG_INV_CRIT_DENSITY,
    REG_RATIO_REAL,
    REG_RATIO_IMAG
  } cfg_reg_t;

  // Saturated value plus its overflow flag
  typedef struct packed {
    acc_t v;
    logic o;
  } sres_t;

  typedef struct packed {
    logic [CW-1:0] v;
    logic          o;
  } cres_t;

  function automatic sres_t clamp_acc(wide_t t);
    sres_t r;
    r.v = t[ACC_W-1:0];
    r.o = 1'b0;
    if (t > WMAX) begin
      r.v = ACC_MAX;
      r.o = 1'b1;
    end else if (t < -WMAX) begin
      r.v = -ACC_MAX;
      r.o = 1'b1;
    end
    return r;
  endfunction

  function automatic sres_t sadd(acc_t a, acc_t b);
    return clamp_acc(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic sres_t ssub(acc_t a, acc_t b);
    return clamp_acc(wide_t'(a) - wide_t'(b));
  endfunction

  // Saturate to one output component
  function automatic cres_t fsat(acc_t v);
    cres_t r;
    acc_t  t;
    t   = v;
    r.o = 1'b0;
    if (v > CMAX) begin
      t   = CMAX;
      r.o = 1'b1;
    end else if (v < CMIN) begin
      t   = CMIN;
      r.o = 1'b1;
    end
    r.v = t[CW-1:0];
    return r;
  endfunction

  // Pick the real (upper) or imaginary (lower) component of a packed word
  function automatic acc_t part_of(logic [2*CW-1:0] w, logic up);
    return up ? acc_t'($signed(w[2*CW-1:CW])) : acc_t'($signed(w[CW-1:0]));
  endfunction

endpackage

/* hdl/lecu_mul.sv */
// Four-stage fixed-point multiplier: magnitude, partial products,
// sum with rounding, then scale, saturate and restore sign.
module lecu_mul import lecu_pkg::*; (
  input  logic clk,
  input  acc_t a,
  input  acc_t b,
  output acc_t p,
  output logic ovf
);

  localparam int HW = ACC_W / 2;
  localparam int PW = 2 * ACC_W;
  localparam int QW = PW - FB;
  localparam logic [QW-1:0] QMAX = QW'(ACC_MAX);
  localparam logic [PW-1:0] RND  = PW'(1) << (FB - 1);

  logic [ACC_W-1:0] ua_r, ub_r;
  logic             neg1_r, neg2_r, neg3_r;
  logic [ACC_W-1:0] p00_r, p01_r, p10_r, p11_r;
  logic [PW-1:0]    prod_r;
  acc_t             p_r;
  logic             ovf_r;

  logic [ACC_W-1:0] a_lo, a_hi, b_lo, b_hi;
  logic             q_sat;
  acc_t             mag;

  assign a_lo = ACC_W'(ua_r[HW-1:0]);
  assign a_hi = ACC_W'(ua_r[ACC_W-1:HW]);
  assign b_lo = ACC_W'(ub_r[HW-1:0]);
  assign b_hi = ACC_W'(ub_r[ACC_W-1:HW]);

  // Scale the magnitude down and clamp it
  always_comb begin
    q_sat = prod_r[PW-1:FB] > QMAX;
    mag   = q_sat ? ACC_MAX : acc_t'(prod_r[FB+ACC_W-1:FB]);
  end

  always_ff @(posedge clk) begin
    ua_r   <= (a < 0) ? -a : a;
    ub_r   <= (b < 0) ? -b : b;
    neg1_r <= a[ACC_W-1] ^ b[ACC_W-1];

    p00_r  <= a_lo * b_lo;
    p01_r  <= a_lo * b_hi;
    p10_r  <= a_hi * b_lo;
    p11_r  <= a_hi * b_hi;
    neg2_r <= neg1_r;

    prod_r <= PW'(p00_r) + (PW'(p01_r) << HW) + (PW'(p10_r) << HW)
              + (PW'(p11_r) << ACC_W) + RND;
    neg3_r <= neg2_r;

    p_r    <= neg3_r ? -mag : mag;
    ovf_r  <= q_sat;
  end

  assign p   = p_r;
  assign ovf = ovf_r;

endmodule

/* hdl/laser_envelope_cell_update.sv */
// One time step of the complex laser-envelope update for one grid cell per
// clock. Raise start with the stencil fields; an item is taken in every cycle
// that start is high (busy stays low) and its result appears with out_valid high
// for exactly one cycle, in order. The result cannot be held off, so the
// receiver must take it when the strobe shows. The pipeline depth comes from the
// chain of six dependent four-stage multipliers plus the saturating adds
// between them. Write the registers over cfg_* only while no item is in
// flight; cfg_ready is always high.
module laser_envelope_cell_update import lecu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_pot_center,
  input  logic [63:0] in_pot_xm1,
  input  logic [63:0] in_pot_xp1,
  input  logic [63:0] in_pot_xm2,
  input  logic [63:0] in_pot_xp2,
  input  logic [63:0] in_pot_ym1,
  input  logic [63:0] in_pot_yp1,
  input  logic [63:0] in_pot_zm1,
  input  logic [63:0] in_pot_zp1,
  input  logic [63:0] in_pot_now,
  input  logic [63:0] in_pot_prev,
  input  logic [30:0] in_electron_density,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [63:0] out_pot_next,
  output logic        out_overflow
);

  typedef struct packed {
    logic [63:0] c, xm1, xp1, xm2, xp2, ym1, yp1, zm1, zp1, now, prev;
    logic [30:0] ne;
  } raw_t;

  typedef struct packed {
    acc_t [1:0] d1, d2, dyy, dzz, g1, g2, now, prev;
    acc_t       aa, ix2, hx, ts2;
    acc_t [1:0] yy, zz, cn, tx, tg, pp, lp, sv;
    logic       ov;
  } ctx_t;

  logic signed [31:0] inv_step_x_r, inv_step_y_sq_r, inv_step_z_sq_r, delta_coef_r;
  logic signed [31:0] ratio_real_r, ratio_imag_r;
  logic [30:0]        time_step_r, inv_crit_density_r;

  logic               in_accept;
  raw_t               in0_r;
  ctx_t               ctx_r   [1:LAT-1];
  ctx_t               ctx_nxt [1:LAT-1];
  logic [LAT-1:0]     vld_r;

  acc_t               ma [NMUL];
  acc_t               mb [NMUL];
  acc_t               mp [NMUL];
  logic [NMUL-1:0]    mo;

  logic               out_valid_r, out_overflow_r;
  logic [63:0]        out_pot_next_r;
  cres_t              fin_re, fin_im;
  acc_t               ts_ext;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy;
  assign ts_ext    = acc_t'({1'b0, time_step_r});

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_step_x_r       <= RST_ONE;
      inv_step_y_sq_r    <= RST_ONE;
      inv_step_z_sq_r    <= RST_ONE;
      delta_coef_r       <= '0;
      time_step_r        <= RST_TS;
      inv_crit_density_r <= RST_ONE[30:0];
      ratio_real_r       <= RST_RATIO;
      ratio_imag_r       <= RST_RATIO;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INV_STEP_X:       inv_step_x_r       <= cfg_data;
        REG_INV_STEP_Y_SQ:    inv_step_y_sq_r    <= cfg_data;
        REG_INV_STEP_Z_SQ:    inv_step_z_sq_r    <= cfg_data;
        REG_DELTA_COEF:       delta_coef_r       <= cfg_data;
        REG_TIME_STEP:        time_step_r        <= cfg_data[30:0];
        REG_INV_CRIT_DENSITY: inv_crit_density_r <= cfg_data[30:0];
        REG_RATIO_REAL:       ratio_real_r       <= cfg_data;
        REG_RATIO_IMAG:       ratio_imag_r       <= cfg_data;
      endcase
    end
  end

  // Multiplier bank
  for (genvar i = 0; i < NMUL; i++) begin : g_mul
    lecu_mul u_mul (
      .clk (clk),
      .a   (ma[i]),
      .b   (mb[i]),
      .p   (mp[i]),
      .ovf (mo[i])
    );
  end

  // Route multiplier operands; a product is ready four stages after its feed
  always_comb begin
    // stage 0: coefficients derived from registers and density
    ma[0] = acc_t'(delta_coef_r);               mb[0] = QUARTER;
    ma[1] = acc_t'(delta_coef_r);               mb[1] = HALF;
    ma[2] = acc_t'(inv_step_x_r);               mb[2] = acc_t'(inv_step_x_r);
    ma[3] = acc_t'(inv_step_x_r);               mb[3] = HALF;
    ma[4] = acc_t'({1'b0, in0_r.ne});           mb[4] = acc_t'({1'b0, inv_crit_density_r});
    ma[5] = ts_ext;                             mb[5] = ts_ext;
    ma[6] = K0;                                 mb[6] = ts_ext;
    // stage 4: stencil terms
    for (int p = 0; p < 2; p++) begin
      ma[7+p]  = ctx_r[4].aa;                   mb[7+p]  = ctx_r[4].d1[p];
      ma[9+p]  = mp[0];                         mb[9+p]  = ctx_r[4].d2[p];
      ma[11+p] = ctx_r[4].aa;                   mb[11+p] = ctx_r[4].g1[p];
      ma[13+p] = mp[1];                         mb[13+p] = ctx_r[4].g2[p];
      ma[15+p] = ctx_r[4].dyy[p];               mb[15+p] = acc_t'(inv_step_y_sq_r);
      ma[17+p] = ctx_r[4].dzz[p];               mb[17+p] = acc_t'(inv_step_z_sq_r);
      ma[19+p] = mp[4];                         mb[19+p] = ctx_r[4].now[p];
    end
    ma[21] = mp[6];                             mb[21] = ctx_r[4].prev[1];
    ma[22] = mp[6];                             mb[22] = ctx_r[4].prev[0];
    for (int p = 0; p < 2; p++) begin
      // stage 9: x scaling of Laplacian and gradient
      ma[23+p] = ctx_r[9].tx[p];                mb[23+p] = ctx_r[9].ix2;
      ma[25+p] = ctx_r[9].tg[p];                mb[25+p] = ctx_r[9].hx;
      // stage 13: 2 k0 times gradient
      ma[27+p] = K20;                           mb[27+p] = mp[25+p];
      // stage 18: times ts^2
      ma[29+p] = ctx_r[18].lp[p];               mb[29+p] = ctx_r[18].ts2;
    end
    // stage 24: complex product with the ratio
    ma[31] = ctx_r[24].sv[0];                   mb[31] = acc_t'(ratio_real_r);
    ma[32] = ctx_r[24].sv[1];                   mb[32] = acc_t'(ratio_imag_r);
    ma[33] = ctx_r[24].sv[0];                   mb[33] = acc_t'(ratio_imag_r);
    ma[34] = ctx_r[24].sv[1];                   mb[34] = acc_t'(ratio_real_r);
  end

  // Stage logic
  always_comb begin
    sres_t r;
    acc_t  c;

    // stage 1: exact stencil differences
    ctx_nxt[1] = '0;
    for (int p = 0; p < 2; p++) begin
      c = part_of(in0_r.c, p == 0);
      ctx_nxt[1].d1[p]  = part_of(in0_r.xm1, p == 0) - (c <<< 1) + part_of(in0_r.xp1, p == 0);
      ctx_nxt[1].d2[p]  = part_of(in0_r.xm2, p == 0) - (c <<< 1) + part_of(in0_r.xp2, p == 0);
      ctx_nxt[1].dyy[p] = part_of(in0_r.ym1, p == 0) - (c <<< 1) + part_of(in0_r.yp1, p == 0);
      ctx_nxt[1].dzz[p] = part_of(in0_r.zm1, p == 0) - (c <<< 1) + part_of(in0_r.zp1, p == 0);
      ctx_nxt[1].g1[p]  = part_of(in0_r.xp1, p == 0) - part_of(in0_r.xm1, p == 0);
      ctx_nxt[1].g2[p]  = part_of(in0_r.xp2, p == 0) - part_of(in0_r.xm2, p == 0);
      ctx_nxt[1].now[p]  = part_of(in0_r.now, p == 0);
      ctx_nxt[1].prev[p] = part_of(in0_r.prev, p == 0);
    end
    ctx_nxt[1].aa = ONE + acc_t'(delta_coef_r);

    // advance everything else one stage
    for (int s = 2; s < LAT; s++) begin
      ctx_nxt[s] = ctx_r[s-1];
    end

    // stage 5: keep the coefficients needed later
    ctx_nxt[5].ix2 = mp[2];
    ctx_nxt[5].hx  = mp[3];
    ctx_nxt[5].ts2 = mp[5];
    ctx_nxt[5].ov  = ctx_r[4].ov | (|mo[6:0]);

    // stage 9: combine x terms, form (1 + i kt) prev
    ctx_nxt[9].ov = ctx_r[8].ov | (|mo[22:7]);
    for (int p = 0; p < 2; p++) begin
      r = ssub(mp[7+p], mp[9+p]);
      ctx_nxt[9].tx[p] = r.v;
      ctx_nxt[9].ov    = ctx_nxt[9].ov | r.o;
      r = ssub(mp[11+p], mp[13+p]);
      ctx_nxt[9].tg[p] = r.v;
      ctx_nxt[9].ov    = ctx_nxt[9].ov | r.o;
      ctx_nxt[9].yy[p] = mp[15+p];
      ctx_nxt[9].zz[p] = mp[17+p];
      ctx_nxt[9].cn[p] = mp[19+p];
    end
    r = ssub(ctx_r[8].prev[0], mp[21]);
    ctx_nxt[9].pp[0] = r.v;
    ctx_nxt[9].ov    = ctx_nxt[9].ov | r.o;
    r = sadd(ctx_r[8].prev[1], mp[22]);
    ctx_nxt[9].pp[1] = r.v;
    ctx_nxt[9].ov    = ctx_nxt[9].ov | r.o;

    // stages 14 to 16: Laplacian, then minus chi times now
    ctx_nxt[14].ov = ctx_r[13].ov | (|mo[26:23]);
    for (int p = 0; p < 2; p++) begin
      r = sadd(mp[23+p], ctx_r[13].yy[p]);
      ctx_nxt[14].lp[p] = r.v;
      ctx_nxt[14].ov    = ctx_nxt[14].ov | r.o;
      r = sadd(ctx_r[14].lp[p], ctx_r[14].zz[p]);
      ctx_nxt[15].lp[p] = r.v;
      ctx_nxt[15].ov    = ctx_nxt[15].ov | r.o;
      r = ssub(ctx_r[15].lp[p], ctx_r[15].cn[p]);
      ctx_nxt[16].lp[p] = r.v;
      ctx_nxt[16].ov    = ctx_nxt[16].ov | r.o;
    end

    // stage 18: add i times 2 k0 grad
    ctx_nxt[18].ov = ctx_r[17].ov | (|mo[28:27]);
    r = ssub(ctx_r[17].lp[0], mp[28]);
    ctx_nxt[18].lp[0] = r.v;
    ctx_nxt[18].ov    = ctx_nxt[18].ov | r.o;
    r = sadd(ctx_r[17].lp[1], mp[27]);
    ctx_nxt[18].lp[1] = r.v;
    ctx_nxt[18].ov    = ctx_nxt[18].ov | r.o;

    // stages 23 and 24: u ts^2 + 2 now - (1 + i kt) prev
    ctx_nxt[23].ov = ctx_r[22].ov | (|mo[30:29]);
    for (int p = 0; p < 2; p++) begin
      r = sadd(mp[29+p], ctx_r[22].now[p] + ctx_r[22].now[p]);
      ctx_nxt[23].sv[p] = r.v;
      ctx_nxt[23].ov    = ctx_nxt[23].ov | r.o;
      r = ssub(ctx_r[23].sv[p], ctx_r[23].pp[p]);
      ctx_nxt[24].sv[p] = r.v;
      ctx_nxt[24].ov    = ctx_nxt[24].ov | r.o;
    end

    // stage 29: sum the ratio products
    ctx_nxt[29].ov = ctx_r[28].ov | (|mo[34:31]);
    r = ssub(mp[31], mp[32]);
    ctx_nxt[29].sv[0] = r.v;
    ctx_nxt[29].ov    = ctx_nxt[29].ov | r.o;
    r = sadd(mp[33], mp[34]);
    ctx_nxt[29].sv[1] = r.v;
    ctx_nxt[29].ov    = ctx_nxt[29].ov | r.o;
  end

  // Final saturation to the component width
  always_comb begin
    fin_re = fsat(ctx_r[LAT-1].sv[0]);
    fin_im = fsat(ctx_r[LAT-1].sv[1]);
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    in0_r <= '{c: in_pot_center, xm1: in_pot_xm1, xp1: in_pot_xp1, xm2: in_pot_xm2,
               xp2: in_pot_xp2, ym1: in_pot_ym1, yp1: in_pot_yp1, zm1: in_pot_zm1,
               zp1: in_pot_zp1, now: in_pot_now, prev: in_pot_prev,
               ne: in_electron_density};
    for (int s = 1; s < LAT; s++) begin
      ctx_r[s] <= ctx_nxt[s];
    end
    out_pot_next_r <= {fin_re.v, fin_im.v};
    out_overflow_r <= ctx_r[LAT-1].ov | fin_re.o | fin_im.o;
  end

  // Valid bits travel with the items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[LAT-2:0], in_accept};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pot_next = out_pot_next_r;
  assign out_overflow = out_overflow_r;

`ifndef SYNTHESIS
  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, LAT + 1))
    else $error("result strobe without a matching accepted item");

  a_zero_in_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($past(in_pot_center | in_pot_xm1 | in_pot_xp1 | in_pot_xm2 | in_pot_xp2
      | in_pot_ym1 | in_pot_yp1 | in_pot_zm1 | in_pot_zp1 | in_pot_now | in_pot_prev, LAT + 1)
      == 64'd0) |-> out_pot_next == 64'd0 && !out_overflow)
    else $error("all-zero stencil did not give a zero result");

  a_mul_sat_clamps: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[13] && mo[23] |-> mp[23] == ACC_MAX || mp[23] == -ACC_MAX)
    else $error("multiplier overflow without a clamped product");
`endif

endmodule

/* bench/laser_envelope_cell_update_tb.sv */
`timescale 1ns / 1ps

module laser_envelope_cell_update_tb;
  import lecu_pkg::*;

  localparam longint ACC_LIM = 64'sh7FFF_FFFF_FFFF;
  localparam int     CYCLE_LIMIT = 400000;

  typedef struct {
    logic [63:0] pot [11];
    logic [30:0] density;
  } cell_t;

  typedef struct {
    logic [63:0] pot_next;
    logic        overflow;
  } update_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] pot_in [11];
  logic [30:0] density_in;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        out_valid;
  logic [63:0] out_pot_next;
  logic        out_overflow;

  // Register copy held by the predictor
  longint  coef [8];
  bit      sat_seen;
  update_t pending_updates [$];
  int      errors;
  int      cells_sent;
  int      updates_checked;
  int      sat_updates;
  int      cycles;
  bit      idle_on;

  laser_envelope_cell_update DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pot_center(pot_in[0]), .in_pot_xm1(pot_in[1]), .in_pot_xp1(pot_in[2]),
    .in_pot_xm2(pot_in[3]), .in_pot_xp2(pot_in[4]), .in_pot_ym1(pot_in[5]),
    .in_pot_yp1(pot_in[6]), .in_pot_zm1(pot_in[7]), .in_pot_zp1(pot_in[8]),
    .in_pot_now(pot_in[9]), .in_pot_prev(pot_in[10]),
    .in_electron_density(density_in),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_pot_next(out_pot_next), .out_overflow(out_overflow)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Saturate to the internal accumulator range
  function automatic longint clip(longint v);
    if (v > ACC_LIM) begin
      sat_seen = 1'b1;
      return ACC_LIM;
    end
    if (v < -ACC_LIM) begin
      sat_seen = 1'b1;
      return -ACC_LIM;
    end
    return v;
  endfunction

  // Fixed-point product, magnitude rounded half away from zero
  function automatic longint qmul(longint a, longint b);
    bit           neg;
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] prod;
    longint       mag;
    neg  = (a < 0) != (b < 0);
    ma   = {64'd0, (a < 0) ? -a : a};
    mb   = {64'd0, (b < 0) ? -b : b};
    prod = ((ma * mb) + (128'd1 << (FB - 1))) >> FB;
    if (prod > 128'(ACC_LIM)) begin
      sat_seen = 1'b1;
      mag = ACC_LIM;
    end else begin
      mag = longint'(prod[63:0]);
    end
    return neg ? -mag : mag;
  endfunction

  function automatic longint comp(logic [63:0] w, bit up);
    return up ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
  endfunction

  function automatic logic [31:0] to_component(longint v);
    if (v > 64'sh7FFF_FFFF) begin
      sat_seen = 1'b1;
      v = 64'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      sat_seen = 1'b1;
      v = -64'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Compute the next potential of one cell from the current coefficients
  function automatic update_t advance_cell(cell_t c);
    longint  one, amp, qd, hd, ix2, hx, chi, ts2, kt;
    longint  lap [2];
    longint  grad [2];
    longint  now [2];
    longint  prv [2];
    longint  ctr, d1, d2, dyy, dzz, g1, g2, tx, tg;
    longint  ure, uim, pre, pim, sre, sim, nre, nim;
    update_t r;
    one      = longint'(1) << FB;
    sat_seen = 1'b0;
    amp = clip(one + coef[REG_DELTA_COEF]);
    qd  = qmul(coef[REG_DELTA_COEF], one >> 2);
    hd  = qmul(coef[REG_DELTA_COEF], one >> 1);
    ix2 = qmul(coef[REG_INV_STEP_X], coef[REG_INV_STEP_X]);
    hx  = qmul(coef[REG_INV_STEP_X], one >> 1);
    chi = qmul(longint'(c.density), coef[REG_INV_CRIT_DENSITY]);
    ts2 = qmul(coef[REG_TIME_STEP], coef[REG_TIME_STEP]);
    kt  = qmul(10 * one, coef[REG_TIME_STEP]);
    for (int p = 0; p < 2; p++) begin
      ctr = comp(c.pot[0], p == 0);
      d1  = comp(c.pot[1], p == 0) - 2 * ctr + comp(c.pot[2], p == 0);
      d2  = comp(c.pot[3], p == 0) - 2 * ctr + comp(c.pot[4], p == 0);
      dyy = comp(c.pot[5], p == 0) - 2 * ctr + comp(c.pot[6], p == 0);
      dzz = comp(c.pot[7], p == 0) - 2 * ctr + comp(c.pot[8], p == 0);
      g1  = comp(c.pot[2], p == 0) - comp(c.pot[1], p == 0);
      g2  = comp(c.pot[4], p == 0) - comp(c.pot[3], p == 0);
      tx  = clip(qmul(amp, d1) - qmul(qd, d2));
      tg  = clip(qmul(amp, g1) - qmul(hd, g2));
      lap[p]  = clip(clip(qmul(tx, ix2) + qmul(dyy, coef[REG_INV_STEP_Y_SQ]))
                     + qmul(dzz, coef[REG_INV_STEP_Z_SQ]));
      grad[p] = qmul(tg, hx);
      now[p]  = comp(c.pot[9], p == 0);
      prv[p]  = comp(c.pot[10], p == 0);
    end
    ure = clip(clip(lap[0] - qmul(chi, now[0])) - qmul(20 * one, grad[1]));
    uim = clip(clip(lap[1] - qmul(chi, now[1])) + qmul(20 * one, grad[0]));
    pre = clip(prv[0] - qmul(kt, prv[1]));
    pim = clip(prv[1] + qmul(kt, prv[0]));
    sre = clip(clip(qmul(ure, ts2) + clip(now[0] + now[0])) - pre);
    sim = clip(clip(qmul(uim, ts2) + clip(now[1] + now[1])) - pim);
    nre = clip(qmul(sre, coef[REG_RATIO_REAL]) - qmul(sim, coef[REG_RATIO_IMAG]));
    nim = clip(qmul(sre, coef[REG_RATIO_IMAG]) + qmul(sim, coef[REG_RATIO_REAL]));
    r.pot_next[63:32] = to_component(nre);
    r.pot_next[31:0]  = to_component(nim);
    r.overflow        = sat_seen;
    return r;
  endfunction

  // Compare each strobed update against the oldest prediction
  always @(posedge clk) begin
    update_t exp_u;
    if (rst_n && out_valid) begin
      if (pending_updates.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected update: pot_next=%h overflow=%b", out_pot_next, out_overflow);
      end else begin
        exp_u = pending_updates.pop_front();
        updates_checked++;
        if (exp_u.overflow)
          sat_updates++;
        if (out_pot_next !== exp_u.pot_next || out_overflow !== exp_u.overflow) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: pot_next exp %h got %h, overflow exp %b got %b",
                     exp_u.pot_next, out_pot_next, exp_u.overflow, out_overflow);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Drop start and wait out a random gap
  task automatic idle_burst();
    int n;
    n = $urandom_range(1, 11);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Present one cell and hold it until it is taken
  task automatic send_cell(cell_t c);
    start <= 1'b1;
    for (int i = 0; i < 11; i++)
      pot_in[i] <= c.pot[i];
    density_in <= c.density;
    do @(posedge clk); while (busy);
    pending_updates.push_back(advance_cell(c));
    cells_sent++;
    if (idle_on && $urandom_range(0, 3) == 0)
      idle_burst();
  endtask

  // Let the pipeline empty before touching the registers
  task automatic drain();
    start <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic write_coef(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TIME_STEP || idx == REG_INV_CRIT_DENSITY)
      coef[idx] = longint'(val[30:0]);
    else
      coef[idx] = longint'($signed(val));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] v [8]);
    cfg_reg_t idx;
    drain();
    for (int i = 0; i < 8; i++) begin
      idx = cfg_reg_t'(i);
      write_coef(idx, v[i]);
    end
  endtask

  function automatic logic [31:0] rand_component();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    for (int i = 0; i < 11; i++)
      c.pot[i] = {rand_component(), rand_component()};
    c.density = ($urandom_range(0, 2) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 1 << 18));
    return c;
  endfunction

  function automatic cell_t flat_cell(logic [31:0] re, logic [31:0] im, logic [30:0] ne);
    cell_t c;
    for (int i = 0; i < 11; i++)
      c.pot[i] = {re, im};
    c.density = ne;
    return c;
  endfunction

  // Extremes of every field under the reset coefficients, then random cells
  task automatic test_directed_cells();
    cell_t c;
    send_cell(flat_cell(32'h0, 32'h0, 31'h0));
    send_cell(flat_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_cell(flat_cell(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF));
    send_cell(flat_cell(32'h0001_0000, 32'hFFFF_0000, 31'h0001_0000));
    send_cell(flat_cell(32'hFFFF_FFFF, 32'h0000_0001, 31'h0));
    // Alternate extremes across the stencil to push the Laplacian to its limits
    c = flat_cell(32'h8000_0000, 32'h7FFF_FFFF, 31'h0);
    c.pot[0] = {32'h7FFF_FFFF, 32'h8000_0000};
    send_cell(c);
    c.pot[0] = 64'h8000_0000_7FFF_FFFF;
    for (int i = 1; i < 9; i++)
      c.pot[i] = 64'h7FFF_FFFF_8000_0000;
    send_cell(c);
    // Strong x gradient
    c = flat_cell(32'h0, 32'h0, 31'h100);
    c.pot[2] = 64'h7FFF_FFFF_7FFF_FFFF;
    c.pot[1] = 64'h8000_0000_8000_0000;
    send_cell(c);
    c.pot[4] = 64'h7FFF_FFFF_8000_0000;
    c.pot[3] = 64'h8000_0000_7FFF_FFFF;
    send_cell(c);
    for (int i = 0; i < 6; i++)
      send_cell(rand_cell());
  endtask

  // Coefficient extremes, each followed by a few cells
  task automatic test_coef_extremes();
    logic [31:0] v [8];
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 8; i++)
        case (k)
          0: v[i] = 32'h7FFF_FFFF;
          1: v[i] = 32'h8000_0000;
          2: v[i] = 32'h0;
          default: v[i] = 32'hFFFF_FFFF;
        endcase
      write_all(v);
      for (int n = 0; n < 5; n++)
        send_cell(rand_cell());
    end
  endtask

  // Realistic coefficients with random cells, several settings
  task automatic test_random_cells(int count, int phases);
    logic [31:0] v [8];
    for (int ph = 0; ph < phases; ph++) begin
      v[REG_INV_STEP_X]       = $urandom_range(1 << 14, 1 << 18);
      v[REG_INV_STEP_Y_SQ]    = $urandom_range(1 << 12, 1 << 19);
      v[REG_INV_STEP_Z_SQ]    = $urandom_range(1 << 12, 1 << 19);
      v[REG_DELTA_COEF]       = 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
      v[REG_TIME_STEP]        = $urandom_range(1 << 8, 1 << 15);
      v[REG_INV_CRIT_DENSITY] = $urandom_range(0, 1 << 17);
      v[REG_RATIO_REAL]       = $urandom_range(0, 1 << 16);
      v[REG_RATIO_IMAG]       = 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
      if (ph % 4 == 3)
        for (int i = 0; i < 8; i++)
          v[i] = $urandom();
      write_all(v);
      for (int n = 0; n < count / phases; n++)
        send_cell(rand_cell());
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_INV_STEP_X;
    cfg_data   = 32'h0;
    density_in = 31'h0;
    for (int i = 0; i < 11; i++)
      pot_in[i] = 64'h0;
    errors = 0;
    idle_on = 1'b1;
    coef[REG_INV_STEP_X]       = 1 << FB;
    coef[REG_INV_STEP_Y_SQ]    = 1 << FB;
    coef[REG_INV_STEP_Z_SQ]    = 1 << FB;
    coef[REG_DELTA_COEF]       = 0;
    coef[REG_TIME_STEP]        = 6554;
    coef[REG_INV_CRIT_DENSITY] = 1 << FB;
    coef[REG_RATIO_REAL]       = 1 << (FB - 1);
    coef[REG_RATIO_IMAG]       = 1 << (FB - 1);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cells();
    test_coef_extremes();
    test_random_cells(1200, 12);
    // Run the last part back to back
    idle_on = 1'b0;
    test_random_cells(360, 3);

    start <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    $display("sent %0d cells over 20 coefficient settings, checked %0d updates (%0d saturated)",
             cells_sent, updates_checked, sat_updates);
    if (errors == 0 && pending_updates.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* filelist.f */
hdl/lecu_pkg.sv
hdl/lecu_mul.sv
hdl/laser_envelope_cell_update.sv
bench/laser_envelope_cell_update_tb.sv
